>>> src/pci_pkg.sv
// shared types, codes and helpers for the path crossing interpolator
// no dependencies
`default_nettype none
package pci_pkg;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_FULL  = 3'd1,
    ST_BELOW = 3'd2,
    ST_FEW   = 3'd3,
    ST_ZERO  = 3'd4
  } status_t;

  // quotient cap of the interpolation divide
  localparam int QW = 41;
  localparam logic [QW-1:0] QCAP = {1'b1, {(QW-1){1'b0}}};

  typedef struct packed {
    op_t                op;
    logic signed [31:0] point_position;
    logic signed [31:0] point_time;
    logic signed [31:0] point_velocity;
    logic signed [31:0] query_position;
  } item_t;

  // request to the multiply-divide unit: a * b / d, all magnitudes
  typedef struct packed {
    logic        start;
    logic [32:0] a;
    logic [32:0] b;
    logic [32:0] d;
  } md_req_t;

  typedef struct packed {
    logic          done;
    logic [QW-1:0] quo;
  } md_rsp_t;

  typedef enum logic [1:0] {
    U_IDLE,
    U_MUL,
    U_DIV
  } md_state_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_SCAN0,
    B_SCAN,
    B_UDIV,
    B_FA,
    B_FB,
    B_FC,
    B_TDIV,
    B_VDIV
  } back_state_t;

  // magnitude of a 33-bit signed value
  function automatic logic [32:0] mag33(input logic signed [32:0] v);
    mag33 = v[32] ? 33'(-v) : 33'(v);
  endfunction

  // base plus or minus the capped quotient, saturated to 32 bits
  function automatic logic signed [31:0] combine(input logic signed [31:0] base,
                                                 input logic [QW-1:0] qm,
                                                 input logic neg);
    logic signed [QW+1:0] b_ext;
    logic signed [QW+1:0] q_ext;
    logic signed [QW+1:0] r;
    b_ext = (QW+2)'(base);
    q_ext = signed'({2'b00, qm});
    r = neg ? b_ext - q_ext : b_ext + q_ext;
    if (r > (QW+2)'(64'sd2147483647)) combine = 32'sh7fffffff;
    else if (r < (QW+2)'(-64'sd2147483648)) combine = 32'sh80000000;
    else combine = r[31:0];
  endfunction

endpackage
`default_nettype wire

>>> src/pci_front.sv
// front end: accepts requests and queues them for the back end
// depends on pci_pkg
`default_nettype none
module pci_front (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   start,
  input  wire pci_pkg::item_t   in_item,
  output logic                  busy,
  output logic                  head_valid,
  output pci_pkg::item_t        head,
  input  wire                   pop
);

  pci_pkg::item_t entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;

  assign busy       = (count == 2'd2);
  assign push       = start && !busy;
  assign head_valid = (count != 2'd0);
  assign head       = entries[rd_ptr];

  // two-entry request queue
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop && head_valid) rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop && head_valid);
    end
    if (push) entries[wr_ptr] <= in_item;
  end

endmodule
`default_nettype wire

>>> src/pci_muldiv.sv
// serial unit: a * b by shift-add, then / d by restoring division, capped quotient
// depends on pci_pkg
`default_nettype none
module pci_muldiv (
  input  wire                    clk,
  input  wire                    rst,
  input  wire pci_pkg::md_req_t  req,
  output pci_pkg::md_rsp_t       rsp
);

  pci_pkg::md_state_t st, st_next;
  logic [6:0]  cnt;
  logic [65:0] prod;
  logic [32:0] mcand;
  logic [32:0] dvs;
  logic [33:0] rem;
  logic        done, done_next;
  logic [33:0] sum;
  logic [33:0] shifted;
  logic        ge;

  assign sum     = {1'b0, prod[65:33]} + (prod[0] ? {1'b0, mcand} : 34'd0);
  assign shifted = {rem[32:0], prod[65]};
  assign ge      = (shifted >= {1'b0, dvs});

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= pci_pkg::U_IDLE;
      done <= 1'b0;
    end else begin
      st   <= st_next;
      done <= done_next;
    end
  end

  // next state
  always_comb begin
    st_next   = st;
    done_next = 1'b0;
    unique case (st)
      pci_pkg::U_IDLE: if (req.start) st_next = pci_pkg::U_MUL;
      pci_pkg::U_MUL:  if (cnt == 7'd32) st_next = pci_pkg::U_DIV;
      pci_pkg::U_DIV: begin
        if (cnt == 7'd65) begin
          st_next   = pci_pkg::U_IDLE;
          done_next = 1'b1;
        end
      end
      default: st_next = pci_pkg::U_IDLE;
    endcase
  end

  // one bit per cycle in each phase
  always_ff @(posedge clk) begin
    case (st)
      pci_pkg::U_IDLE: begin
        prod  <= {33'd0, req.b};
        mcand <= req.a;
        dvs   <= req.d;
        cnt   <= 7'd0;
      end
      pci_pkg::U_MUL: begin
        prod <= {sum, prod[32:1]};
        cnt  <= (cnt == 7'd32) ? 7'd0 : cnt + 7'd1;
        rem  <= 34'd0;
      end
      default: begin
        rem  <= ge ? shifted - {1'b0, dvs} : shifted;
        prod <= {prod[64:0], ge};
        cnt  <= cnt + 7'd1;
      end
    endcase
  end

  // cap the quotient at 2^40
  always_comb begin
    rsp.done = done;
    if ((|prod[65:pci_pkg::QW]) || (prod[pci_pkg::QW-1] && (|prod[pci_pkg::QW-2:0])))
      rsp.quo = pci_pkg::QCAP;
    else
      rsp.quo = prod[pci_pkg::QW-1:0];
  end

endmodule
`default_nettype wire

>>> src/pci_back.sv
// back end: point tables, segment search and interpolation sequencer
// depends on pci_pkg and pci_muldiv
`default_nettype none
module pci_back #(
  parameter int MAX_POINTS = 256
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  uniform_spacing,
  input  wire                  head_valid,
  input  wire pci_pkg::item_t  head,
  output logic                 pop,
  output logic                 done,
  output logic [2:0]           status,
  output logic signed [31:0]   cross_time,
  output logic signed [31:0]   cross_velocity
);

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);

  // tables
  logic signed [31:0] pos_mem [MAX_POINTS];
  logic signed [31:0] tim_mem [MAX_POINTS];
  logic signed [31:0] vel_mem [MAX_POINTS];
  logic signed [31:0] pos_rd, tim_rd, vel_rd;
  logic [AW-1:0]      raddr;
  logic               we;

  pci_pkg::back_state_t st, st_next;
  logic [CW-1:0]      n, n_next;
  logic signed [32:0] q, q_next;
  logic signed [31:0] xprev, xprev_next;
  logic [AW-1:0]      i, i_next;
  logic [AW-1:0]      seg, seg_next;
  logic signed [31:0] xs, xs_next;
  logic signed [32:0] w, w_next;
  logic signed [31:0] ta, ta_next, va, va_next, tb, tb_next, vb, vb_next;
  logic signed [31:0] tres, tres_next;
  logic               done_next;
  logic [2:0]         status_next;
  logic signed [31:0] ct_next, cv_next;

  pci_pkg::md_req_t req;
  pci_pkg::md_rsp_t rsp;

  logic signed [32:0] cur_w, dq, dt_cur, dt_reg, dv_reg;
  logic               hit, last;

  pci_muldiv u_md (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      pos_mem[n[AW-1:0]] <= head.point_position;
      tim_mem[n[AW-1:0]] <= head.point_time;
      vel_mem[n[AW-1:0]] <= head.point_velocity;
    end
    pos_rd <= pos_mem[raddr];
    tim_rd <= tim_mem[raddr];
    vel_rd <= vel_mem[raddr];
  end

  assign cur_w  = 33'(pos_rd) - 33'(xprev);
  assign dq     = q - 33'(xs);
  assign dt_cur = 33'(tim_rd) - 33'(ta);
  assign dt_reg = 33'(tb) - 33'(ta);
  assign dv_reg = 33'(vb) - 33'(va);
  assign hit    = (q >= 33'(xprev)) && (q < 33'(pos_rd));
  assign last   = ((CW+1)'(i) + (CW+1)'(2) == (CW+1)'(n));

  // state and data registers
  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= pci_pkg::B_IDLE;
      n    <= '0;
      done <= 1'b0;
    end else begin
      st   <= st_next;
      n    <= n_next;
      done <= done_next;
    end
    q <= q_next; xprev <= xprev_next; i <= i_next; seg <= seg_next;
    xs <= xs_next; w <= w_next; ta <= ta_next; va <= va_next;
    tb <= tb_next; vb <= vb_next; tres <= tres_next;
    status <= status_next; cross_time <= ct_next; cross_velocity <= cv_next;
  end

  // sequencer
  always_comb begin
    st_next = st; n_next = n; q_next = q; xprev_next = xprev; i_next = i;
    seg_next = seg; xs_next = xs; w_next = w; ta_next = ta; va_next = va;
    tb_next = tb; vb_next = vb; tres_next = tres;
    done_next = 1'b0; status_next = status; ct_next = cross_time; cv_next = cross_velocity;
    pop = 1'b0; we = 1'b0; raddr = '0;
    req = '0;
    unique case (st)
      pci_pkg::B_IDLE: begin
        if (head_valid) begin
          pop = 1'b1;
          status_next = pci_pkg::ST_OK;
          ct_next = '0;
          cv_next = '0;
          q_next = 33'(head.query_position);
          unique case (head.op)
            pci_pkg::OP_APPEND: begin
              done_next = 1'b1;
              if (32'(n) >= 32'(MAX_POINTS)) status_next = pci_pkg::ST_FULL;
              else begin
                we = 1'b1;
                n_next = n + CW'(1);
              end
            end
            pci_pkg::OP_CLEAR: begin
              done_next = 1'b1;
              n_next = '0;
            end
            pci_pkg::OP_QUERY: begin
              if (n < CW'(2)) begin
                done_next = 1'b1;
                status_next = pci_pkg::ST_FEW;
              end else st_next = pci_pkg::B_SCAN0;
            end
            default: done_next = 1'b1;
          endcase
        end
      end
      pci_pkg::B_SCAN0: begin
        xprev_next = pos_rd;
        i_next = '0;
        raddr = AW'(1);
        st_next = pci_pkg::B_SCAN;
      end
      pci_pkg::B_SCAN: begin
        if (uniform_spacing) begin
          w_next = cur_w;
          if (cur_w == '0) begin
            done_next = 1'b1; status_next = pci_pkg::ST_ZERO; st_next = pci_pkg::B_IDLE;
          end else begin
            req.start = 1'b1;
            req.a = pci_pkg::mag33(q);
            req.b = 33'd1;
            req.d = pci_pkg::mag33(cur_w);
            st_next = pci_pkg::B_UDIV;
          end
        end else if (hit || (last && q >= 33'(pos_rd))) begin
          seg_next = i;
          w_next = cur_w;
          if (cur_w == '0) begin
            done_next = 1'b1; status_next = pci_pkg::ST_ZERO; st_next = pci_pkg::B_IDLE;
          end else st_next = pci_pkg::B_FA;
        end else if (last) begin
          done_next = 1'b1; status_next = pci_pkg::ST_BELOW; st_next = pci_pkg::B_IDLE;
        end else begin
          xprev_next = pos_rd;
          i_next = i + AW'(1);
          raddr = i + AW'(2);
        end
      end
      pci_pkg::B_UDIV: begin
        if (rsp.done) begin
          // floor index, negative clamps to the first segment, past end to the last
          if (q[32] != w[32]) seg_next = '0;
          else if (rsp.quo >= pci_pkg::QW'(n) - pci_pkg::QW'(1))
            seg_next = AW'(n - CW'(2));
          else seg_next = rsp.quo[AW-1:0];
          st_next = pci_pkg::B_FA;
        end
      end
      pci_pkg::B_FA: begin
        raddr = seg;
        st_next = pci_pkg::B_FB;
      end
      pci_pkg::B_FB: begin
        xs_next = pos_rd;
        ta_next = tim_rd;
        va_next = vel_rd;
        raddr = seg + AW'(1);
        st_next = pci_pkg::B_FC;
      end
      pci_pkg::B_FC: begin
        tb_next = tim_rd;
        vb_next = vel_rd;
        req.start = 1'b1;
        req.a = pci_pkg::mag33(dt_cur);
        req.b = pci_pkg::mag33(dq);
        req.d = pci_pkg::mag33(w);
        st_next = pci_pkg::B_TDIV;
      end
      pci_pkg::B_TDIV: begin
        if (rsp.done) begin
          tres_next = pci_pkg::combine(ta, rsp.quo, (dt_reg[32] != dq[32]) ^ w[32]);
          req.start = 1'b1;
          req.a = pci_pkg::mag33(dv_reg);
          req.b = pci_pkg::mag33(dq);
          req.d = pci_pkg::mag33(w);
          st_next = pci_pkg::B_VDIV;
        end
      end
      pci_pkg::B_VDIV: begin
        if (rsp.done) begin
          done_next = 1'b1;
          status_next = pci_pkg::ST_OK;
          ct_next = tres;
          cv_next = pci_pkg::combine(va, rsp.quo, (dv_reg[32] != dq[32]) ^ w[32]);
          st_next = pci_pkg::B_IDLE;
        end
      end
      default: st_next = pci_pkg::B_IDLE;
    endcase
  end

endmodule
`default_nettype wire

>>> src/path_crossing_interpolator.sv
// top level: request queue, table sequencer and the configuration register
// depends on pci_pkg, pci_front, pci_back
// a spaced-mode query scans the n stored points, reading one point a cycle; each divide
// of a query runs on the shared serial unit
// one request at a time in the back end, two more queue in front; results cannot stall
// reset clears the point count, the queue and uniform_spacing; tables hold no reset
`default_nettype none
module path_crossing_interpolator #(
  parameter int MAX_POINTS = 256
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                start,
  output logic               busy,
  input  wire  [1:0]         op,
  input  wire  signed [31:0] point_position,
  input  wire  signed [31:0] point_time,
  input  wire  signed [31:0] point_velocity,
  input  wire  signed [31:0] query_position,
  output logic               done,
  output logic [2:0]         status,
  output logic signed [31:0] cross_time,
  output logic signed [31:0] cross_velocity,
  input  wire                cfg_valid,
  output logic               cfg_ready,
  input  wire                cfg_data
);

  pci_pkg::item_t in_item;
  pci_pkg::item_t head;
  logic           head_valid;
  logic           pop;
  logic           uniform_spacing;

  assign in_item.op             = pci_pkg::op_t'(op);
  assign in_item.point_position = point_position;
  assign in_item.point_time     = point_time;
  assign in_item.point_velocity = point_velocity;
  assign in_item.query_position = query_position;

  // configuration register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) uniform_spacing <= 1'b0;
    else if (cfg_valid && cfg_ready) uniform_spacing <= cfg_data;
  end

  pci_front u_front (
    .clk(clk), .rst(rst), .start(start), .in_item(in_item), .busy(busy),
    .head_valid(head_valid), .head(head), .pop(pop)
  );

  pci_back #(.MAX_POINTS(MAX_POINTS)) u_back (
    .clk(clk), .rst(rst), .uniform_spacing(uniform_spacing),
    .head_valid(head_valid), .head(head), .pop(pop),
    .done(done), .status(status), .cross_time(cross_time),
    .cross_velocity(cross_velocity)
  );

endmodule
`default_nettype wire

>>> test/tb_path_crossing_interpolator.sv
// self-checking testbench for path_crossing_interpolator: directed and random requests
// checked against an in-bench table predictor; depends on pci_pkg and the block
`timescale 1ns / 100ps
module tb_path_crossing_interpolator;

  localparam int TABLE_DEPTH = 256;
  localparam int RANDOM_ITEMS = 1900;

  typedef struct {
    pci_pkg::status_t st;
    logic [31:0]      t;
    logic [31:0]      v;
  } crossing_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [1:0] op = pci_pkg::OP_NONE;
  logic signed [31:0] point_position = '0;
  logic signed [31:0] point_time = '0;
  logic signed [31:0] point_velocity = '0;
  logic signed [31:0] query_position = '0;
  logic cfg_valid = 1'b0;
  logic cfg_data = 1'b0;
  wire busy, done, cfg_ready;
  wire [2:0] status;
  wire signed [31:0] cross_time, cross_velocity;

  path_crossing_interpolator dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op),
    .point_position(point_position), .point_time(point_time),
    .point_velocity(point_velocity), .query_position(query_position),
    .done(done), .status(status), .cross_time(cross_time),
    .cross_velocity(cross_velocity), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // predictor state
  int unsigned stored_points;
  logic signed [31:0] pos_tab [TABLE_DEPTH];
  logic signed [31:0] time_tab [TABLE_DEPTH];
  logic signed [31:0] vel_tab [TABLE_DEPTH];
  logic uniform_mode;

  crossing_t pending_crossings[$];
  int mismatches = 0;
  int sent_items = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // append one expected crossing to the queue
  function automatic void enqueue_crossing(input crossing_t c);
    pending_crossings = {pending_crossings, c};
  endfunction

  // magnitude widened for the product
  function automatic logic [127:0] mag128(input longint v);
    mag128 = v < 0 ? 128'(-v) : 128'(v);
  endfunction

  // a + (b - a) * dq / w, quotient capped and sum saturated
  function automatic logic [31:0] lerp(input longint a, input longint b,
                                       input longint dq, input longint w);
    logic [127:0] quo;
    logic neg;
    longint r;
    quo = (mag128(b - a) * mag128(dq)) / mag128(w);
    if (quo > (128'd1 << 40)) quo = 128'd1 << 40;
    neg = ((b - a) < 0) != (dq < 0);
    if (w < 0) neg = !neg;
    r = neg ? a - longint'(quo) : a + longint'(quo);
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    lerp = r[31:0];
  endfunction

  // expected crossing for one request, updates the table copy
  function automatic crossing_t predict_crossing(input pci_pkg::op_t o,
                                                 input logic signed [31:0] pp,
                                                 input logic signed [31:0] pt,
                                                 input logic signed [31:0] pv,
                                                 input logic signed [31:0] qp);
    crossing_t res;
    longint q, w, idx, dq;
    int unsigned seg;
    bit found;
    res = '{pci_pkg::ST_OK, 32'd0, 32'd0};
    seg = 0;
    found = 0;
    q = qp;
    w = 0;
    case (o)
      pci_pkg::OP_APPEND: begin
        if (stored_points >= TABLE_DEPTH) res.st = pci_pkg::ST_FULL;
        else begin
          pos_tab[stored_points] = pp;
          time_tab[stored_points] = pt;
          vel_tab[stored_points] = pv;
          stored_points++;
        end
        return res;
      end
      pci_pkg::OP_CLEAR: begin
        stored_points = 0;
        return res;
      end
      pci_pkg::OP_QUERY: ;
      default: return res;
    endcase
    if (stored_points < 2) begin
      res.st = pci_pkg::ST_FEW;
      return res;
    end
    if (uniform_mode) begin
      w = longint'(pos_tab[1]) - longint'(pos_tab[0]);
      if (w == 0) begin
        res.st = pci_pkg::ST_ZERO;
        return res;
      end
      idx = q / w;
      if ((q % w) != 0 && ((q < 0) != (w < 0))) idx--;
      if (idx < 0) idx = 0;
      if (idx >= longint'(stored_points - 1)) idx = longint'(stored_points - 2);
      seg = 32'(idx);
    end else begin
      for (int i = 0; i + 1 < stored_points && !found; i++) begin
        if (q >= pos_tab[i] && q < pos_tab[i+1]) begin
          seg = i;
          found = 1;
        end
      end
      if (!found) begin
        if (q >= pos_tab[stored_points-1]) seg = stored_points - 2;
        else begin
          res.st = pci_pkg::ST_BELOW;
          return res;
        end
      end
      w = longint'(pos_tab[seg+1]) - longint'(pos_tab[seg]);
      if (w == 0) begin
        res.st = pci_pkg::ST_ZERO;
        return res;
      end
    end
    dq = q - longint'(pos_tab[seg]);
    res.t = lerp(time_tab[seg], time_tab[seg+1], dq, w);
    res.v = lerp(vel_tab[seg], vel_tab[seg+1], dq, w);
    return res;
  endfunction

  // result checker
  always @(posedge clk) begin
    crossing_t e;
    if (!rst && done) begin
      if (pending_crossings.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: status %0d", status);
      end else begin
        e = pending_crossings.pop_front();
        if (status !== e.st || cross_time !== e.t || cross_velocity !== e.v) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp st %0d t %h v %h, got st %0d t %h v %h",
                     e.st, e.t, e.v, status, cross_time, cross_velocity);
        end
      end
    end
  end

  // random gap: often none, otherwise mostly short, sometimes long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // send one request; start stays high on return, caller is at the accepting edge
  task automatic send_request(input pci_pkg::op_t o, input logic signed [31:0] pp,
                              input logic signed [31:0] pt, input logic signed [31:0] pv,
                              input logic signed [31:0] qp);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    op <= o;
    point_position <= pp;
    point_time <= pt;
    point_velocity <= pv;
    query_position <= qp;
    do @(posedge clk); while (busy);
    enqueue_crossing(predict_crossing(o, pp, pt, pv, qp));
    sent_items++;
  endtask

  task automatic append_point(input logic signed [31:0] x, input logic signed [31:0] t,
                              input logic signed [31:0] v);
    send_request(pci_pkg::OP_APPEND, x, t, v, $urandom);
  endtask

  task automatic query_at(input logic signed [31:0] q);
    send_request(pci_pkg::OP_QUERY, $urandom, $urandom, $urandom, q);
  endtask

  // drop start and wait until every result is back
  task automatic drain();
    start <= 1'b0;
    while (pending_crossings.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_spacing(input logic val);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    uniform_mode = val;
    cfg_valid <= 1'b0;
  endtask

  // spaced mode: empty table, extremes, last point, below first, zero width
  task automatic test_spaced_directed();
    query_at(32'sh0);
    append_point(32'sh0, 32'sh0, 32'sh0);
    query_at(32'sh10000);
    append_point(32'sh10000, 32'sh7fffffff, 32'sh80000000);
    append_point(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
    query_at(32'sh8000);
    query_at(32'sh0);
    query_at(32'sh7fffffff);
    query_at(32'sh80000000);
    query_at(32'sh7ffffffe);
    send_request(pci_pkg::OP_NONE, 32'shffffffff, 32'shffffffff, 32'shffffffff,
                 32'shffffffff);
    append_point(32'sh7fffffff, 32'sh1, 32'sh2);
    query_at(32'sh7fffffff);
    send_request(pci_pkg::OP_CLEAR, 32'sh0, 32'sh0, 32'sh0, 32'sh0);
    query_at(32'sh7fffffff);
    drain();
  endtask

  // uniform mode: negative index clamp, past end, zero dx, saturation
  task automatic test_uniform_directed();
    write_spacing(1'b1);
    send_request(pci_pkg::OP_CLEAR, 0, 0, 0, 0);
    for (int i = 0; i < 4; i++) append_point(i * 32'sh20000, i * 32'sh40000000, -i * 32'sh100);
    query_at(32'sh80000000);
    query_at(32'sh30000);
    query_at(32'sh60000);
    query_at(32'sh7fffffff);
    query_at(-32'sh1);
    send_request(pci_pkg::OP_CLEAR, 0, 0, 0, 0);
    append_point(32'sh5000, 1, 2);
    append_point(32'sh5000, 3, 4);
    query_at(32'sh5000);
    write_spacing(1'b0);
  endtask

  // fill the table, then one append too many
  task automatic test_full_table();
    send_request(pci_pkg::OP_CLEAR, 0, 0, 0, 0);
    for (int i = 0; i < TABLE_DEPTH; i++) append_point(i << 16, $urandom, $urandom);
    append_point(32'sh12345, 32'sh1, 32'sh1);
    query_at(32'sh00ff8000);
    query_at($urandom_range(0, 32'h00ffffff));
    query_at(32'sh7fffffff);
    send_request(pci_pkg::OP_CLEAR, 0, 0, 0, 0);
    drain();
  endtask

  // random phases of well-formed tables and queries, with some noise
  task automatic test_random_paths();
    longint x, dx;
    int npts;
    logic signed [31:0] lo_pos, hi_pos;
    while (sent_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) == 0) write_spacing(1'($urandom_range(0, 1)));
      send_request(pci_pkg::OP_CLEAR, $urandom, $urandom, $urandom, $urandom);
      npts = ($urandom_range(0, 40) == 0) ? $urandom_range(2, 256) : $urandom_range(0, 10);
      x = ($urandom_range(0, 3) == 0) ? longint'(int'($urandom))
                                      : longint'($urandom_range(0, 32'h40000)) - 64'sd131072;
      dx = ($urandom_range(0, 3) == 0) ? longint'($urandom_range(1, 32'h01000000))
                                       : longint'($urandom_range(1, 32'h30000));
      if ($urandom_range(0, 15) == 0) dx = -dx;
      lo_pos = x[31:0];
      for (int i = 0; i < npts; i++) begin
        if (!uniform_mode && $urandom_range(0, 9) == 0) append_point($urandom, $urandom, $urandom);
        else append_point(x[31:0], $urandom, $urandom);
        x += uniform_mode ? dx
                          : longint'($urandom_range(0, 7) == 0 ? 0 : $urandom_range(1, 32'(dx)));
      end
      hi_pos = x[31:0];
      for (int k = $urandom_range(1, 12); k > 0; k--) begin
        case ($urandom_range(0, 7))
          0: query_at($urandom);
          1: query_at(stored_points > 0 ? pos_tab[$urandom_range(0, stored_points - 1)] : 0);
          2: query_at(lo_pos - $urandom_range(0, 32'h40000));
          3: query_at(hi_pos + $urandom_range(0, 32'h40000));
          4: send_request(pci_pkg::op_t'(($urandom_range(0, 5) == 0) ? pci_pkg::OP_NONE
                                                                     : pci_pkg::OP_APPEND),
                          $urandom, $urandom, $urandom, $urandom);
          default: query_at(lo_pos + $urandom_range(0, 32'(hi_pos - lo_pos)));
        endcase
      end
    end
    drain();
  endtask

  initial begin
    stored_points = 0;
    uniform_mode = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_spaced_directed();
    test_uniform_directed();
    test_full_table();
    test_random_paths();
    repeat (400) @(posedge clk);
    if (mismatches == 0 && pending_crossings.size() == 0) begin
      $display("[path_crossing_interpolator] OK");
    end else begin
      $display("[path_crossing_interpolator] ERROR");
    end
    $finish;
  end

  // run limit
  initial begin
    #200ms;
    $display("[path_crossing_interpolator] ERROR");
    $finish;
  end

endmodule
